@@ rtl/rpcb_pkg.sv @@
// shared constants, codes and types of the pointer chain builder
package rpcb_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;

   // fixed field widths
   localparam int LINK_W = 11;
   localparam int SUM_W  = 20;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int SEED_W = 64;
   localparam int LEN_W  = 11;

   // csr bus
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 64;
   localparam logic [CSR_AW-1:0] CSR_SEED_ADDR = 4'h0;
   localparam logic [CSR_AW-1:0] CSR_LEN_ADDR  = 4'h8;
   localparam logic [SEED_W-1:0] SEED_RESET    = 64'd1;
   localparam logic [LEN_W-1:0]  LEN_RESET     = 11'd1024;

   // xorshift shift amounts
   localparam int XS_A = 21;
   localparam int XS_B = 35;
   localparam int XS_C = 4;

   // remainder bits resolved per cycle
   localparam int MOD_STEPS = 8;

   localparam logic [OP_W-1:0] OP_BUILD = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CHASE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

endpackage

@@ rtl/rpcb_req_if.sv @@
// request channel interface
interface rpcb_req_if;
   logic                          valid;
   logic                          ready;
   logic [rpcb_pkg::OP_W-1:0]     operation;
   logic [rpcb_pkg::LINK_W-1:0]   entry_index;

   modport source (output valid, output operation, output entry_index, input ready);
   modport sink (input valid, input operation, input entry_index, output ready);
endinterface

@@ rtl/rpcb_rsp_if.sv @@
// response channel interface
interface rpcb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rpcb_pkg::LINK_W-1:0]   link_value;
   logic [rpcb_pkg::SUM_W-1:0]    chase_sum;
   logic [rpcb_pkg::LINK_W-1:0]   hop_count;
   logic [rpcb_pkg::STAT_W-1:0]   status;

   modport source (output valid, output link_value, output chase_sum, output hop_count,
                   output status, input ready);
   modport sink (input valid, input link_value, input chase_sum, input hop_count,
                 input status, output ready);
endinterface

@@ rtl/rpcb_mod.sv @@
// iterative 64-bit by narrow modulo unit, several remainder bits per cycle
module rpcb_mod #(
   parameter int AW = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpcb_pkg::SEED_W-1:0]   dividend,
   input  logic [AW-1:0]                 divisor,
   output rpcb_pkg::mod_stat_type        stat,
   output logic [AW-1:0]                 remainder
);
   localparam int CYCLES = rpcb_pkg::SEED_W / rpcb_pkg::MOD_STEPS;
   localparam int CW     = $clog2(CYCLES);

   logic [rpcb_pkg::SEED_W-1:0] q_ff, q_in;
   logic [AW-1:0]               rem_ff, rem_in;
   logic [CW-1:0]               cnt_ff;
   logic                        busy_ff, done_ff;

   // shift-subtract steps on the current chunk
   always_comb begin
      logic [AW:0] t;
      q_in   = q_ff;
      rem_in = rem_ff;
      for (int k = 0; k < rpcb_pkg::MOD_STEPS; k++) begin
         t = {rem_in, q_in[rpcb_pkg::SEED_W-1]};
         q_in = {q_in[rpcb_pkg::SEED_W-2:0], 1'b0};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
         end
         rem_in = t[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;
endmodule

@@ rtl/random_pointer_chain_builder.sv @@
// top level of the random pointer chain builder
// Builds a random pointer-chase chain of N = min(chain_length, MAX_ELEMENTS) entries in an
// on-chip link table, and serves reads of single links and full chase walks. One request is
// taken at a time; ready is low while it runs. A build runs a fill pass over the N shuffle
// entries, then N shuffle steps (xorshift, a modulo in the remainder unit resolving 8 bits
// a cycle, a two-port read and two writes), then a link pass that reads each shuffle entry
// in turn, writes one link and ends the chain with a zero link. A chase walks one hop at a
// time through the single link-table read port. A read of one link passes a table read and
// a wait state. Any op on a chain never built, or a read beyond the built length, goes
// straight to the finish state. The response beat sits in an output register, and a
// finished op only waits if the previous beat has not yet been taken. The tables need no
// clearing pass: every entry a read or chase can reach is written by the build. csr: seed
// at byte 0, chain_length at byte 8.
module random_pointer_chain_builder #(
   parameter int MAX_ELEMENTS = rpcb_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   rpcb_req_if.sink                      req_ch,
   rpcb_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rpcb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rpcb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rpcb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   // link indexes run 0..MAX, shuffle indexes 0..MAX-1
   localparam int AW  = $clog2(MAX_ELEMENTS + 1);
   localparam int SAW = $clog2(MAX_ELEMENTS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FILL  = 4'd1;
   localparam logic [3:0] S_XS    = 4'd2;
   localparam logic [3:0] S_MODW  = 4'd3;
   localparam logic [3:0] S_SRD   = 4'd4;
   localparam logic [3:0] S_SWA   = 4'd5;
   localparam logic [3:0] S_SWB   = 4'd6;
   localparam logic [3:0] S_LRD   = 4'd7;
   localparam logic [3:0] S_LWR   = 4'd8;
   localparam logic [3:0] S_LEND  = 4'd9;
   localparam logic [3:0] S_CRD   = 4'd10;
   localparam logic [3:0] S_CCHK  = 4'd11;
   localparam logic [3:0] S_RRD   = 4'd12;
   localparam logic [3:0] S_RWAIT = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;

   // csr registers
   logic [rpcb_pkg::SEED_W-1:0] seed_ff;
   logic [rpcb_pkg::LEN_W-1:0]  len_ff;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= rpcb_pkg::SEED_RESET;
         len_ff  <= rpcb_pkg::LEN_RESET;
      end else if (csr_wr) begin
         if (csr_paddr == rpcb_pkg::CSR_SEED_ADDR) begin
            seed_ff <= csr_pwdata;
         end else if (csr_paddr == rpcb_pkg::CSR_LEN_ADDR) begin
            len_ff <= csr_pwdata[rpcb_pkg::LEN_W-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == rpcb_pkg::CSR_SEED_ADDR) begin
         csr_prdata = seed_ff;
      end else if (csr_paddr == rpcb_pkg::CSR_LEN_ADDR) begin
         csr_prdata = rpcb_pkg::CSR_DW'(len_ff);
      end
   end

   // sequencer state
   logic [3:0]                  state_ff;
   logic [rpcb_pkg::SEED_W-1:0] x_ff, x_in;
   logic [AW-1:0]               n_ff, n_sat;
   logic [AW-1:0]               i_ff;
   logic [AW-1:0]               pos_ff;
   logic [SAW-1:0]              r_ff;
   logic [AW:0]                 hops_ff;
   logic [rpcb_pkg::SUM_W-1:0]  sum_ff;
   logic [AW-1:0]               res_link_ff;
   logic [rpcb_pkg::STAT_W-1:0] res_stat_ff;
   logic [rpcb_pkg::LINK_W-1:0] idx_ff;
   logic                        built_ff;
   logic [AW-1:0]               built_len_ff;

   // output register
   logic                        rsp_valid_ff;
   logic [rpcb_pkg::LINK_W-1:0] rsp_link_ff;
   logic [rpcb_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic [rpcb_pkg::LINK_W-1:0] rsp_hops_ff;
   logic [rpcb_pkg::STAT_W-1:0] rsp_stat_ff;

   // tables
   logic [AW-1:0] sh_mem [MAX_ELEMENTS];
   logic [AW-1:0] lk_mem [MAX_ELEMENTS + 1];
   logic          sh_we, sh_re, lk_we, lk_re;
   logic [SAW-1:0] sh_wa, sh_ra, sh_rb;
   logic [AW-1:0]  sh_wd, sa_q, sb_q;
   logic [AW-1:0]  lk_wa, lk_wd, lk_ra, lk_q;

   // modulo unit used by the shuffle
   logic                   mod_start;
   rpcb_pkg::mod_stat_type mod_st;
   logic [AW-1:0]          mod_rem;

   logic req_acc, fin_go;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid & req_ch.ready;
   assign fin_go       = (state_ff == S_FIN) & (~rsp_valid_ff | rsp_ch.ready);

   // chain_length above the table size saturates
   assign n_sat = (32'(len_ff) > MAX_ELEMENTS) ? AW'(MAX_ELEMENTS) : AW'(len_ff);

   // one xorshift step
   always_comb begin
      x_in = x_ff ^ (x_ff >> rpcb_pkg::XS_A);
      x_in = x_in ^ (x_in << rpcb_pkg::XS_B);
      x_in = x_in ^ (x_in >> rpcb_pkg::XS_C);
   end

   assign mod_start = (state_ff == S_XS);

   rpcb_mod #(.AW(AW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (x_in),
      .divisor   (n_ff),
      .stat      (mod_st),
      .remainder (mod_rem)
   );

   // memory port steering
   always_comb begin
      sh_we = 1'b0;
      sh_wa = i_ff[SAW-1:0];
      sh_wd = i_ff + 1'b1;
      sh_re = 1'b0;
      sh_ra = i_ff[SAW-1:0];
      sh_rb = r_ff;
      lk_we = 1'b0;
      lk_wa = pos_ff;
      lk_wd = '0;
      lk_re = 1'b0;
      lk_ra = pos_ff;
      unique case (state_ff)
         S_FILL: sh_we = 1'b1;
         S_SRD, S_LRD: sh_re = 1'b1;
         S_SWA: begin
            sh_we = 1'b1;
            sh_wd = sb_q;
         end
         S_SWB: begin
            sh_we = 1'b1;
            sh_wa = r_ff;
            sh_wd = sa_q;
         end
         S_LWR: begin
            lk_we = 1'b1;
            lk_wd = sa_q;
         end
         S_LEND: lk_we = 1'b1;
         S_CRD: lk_re = (32'(hops_ff) <= MAX_ELEMENTS);
         S_RRD: begin
            lk_re = 1'b1;
            lk_ra = AW'(idx_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sh_we) begin
         sh_mem[sh_wa] <= sh_wd;
      end
      if (sh_re) begin
         sa_q <= sh_mem[sh_ra];
         sb_q <= sh_mem[sh_rb];
      end
   end

   always_ff @(posedge clock) begin
      if (lk_we) begin
         lk_mem[lk_wa] <= lk_wd;
      end
      if (lk_re) begin
         lk_q <= lk_mem[lk_ra];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         built_len_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new beat replaces the one taken in the same cycle
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  priority if (req_ch.operation == rpcb_pkg::OP_BUILD) begin
                     state_ff <= (n_sat == '0) ? S_LEND : S_FILL;
                  end else if (req_ch.operation == rpcb_pkg::OP_READ) begin
                     if (built_ff &&
                         32'(req_ch.entry_index) <= 32'(built_len_ff)) begin
                        state_ff <= S_RRD;
                     end else begin
                        state_ff <= S_FIN;
                     end
                  end else if (req_ch.operation == rpcb_pkg::OP_CHASE) begin
                     state_ff <= built_ff ? S_CRD : S_FIN;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_FILL: if (i_ff + 1'b1 == n_ff) state_ff <= S_XS;
            S_XS:   state_ff <= S_MODW;
            S_MODW: if (mod_st.done) state_ff <= S_SRD;
            S_SRD:  state_ff <= S_SWA;
            S_SWA:  state_ff <= S_SWB;
            S_SWB:  state_ff <= (i_ff + 1'b1 == n_ff) ? S_LRD : S_XS;
            S_LRD:  state_ff <= S_LWR;
            S_LWR:  state_ff <= (i_ff + 1'b1 == n_ff) ? S_LEND : S_LRD;
            S_LEND: begin
               built_ff     <= 1'b1;
               built_len_ff <= n_ff;
               state_ff     <= S_FIN;
            end
            S_CRD:  state_ff <= (32'(hops_ff) <= MAX_ELEMENTS) ? S_CCHK : S_FIN;
            S_CCHK: begin
               if (lk_q == '0 || 32'(lk_q) > MAX_ELEMENTS) begin
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_CRD;
               end
            end
            S_RRD:   state_ff <= S_RWAIT;
            S_RWAIT: state_ff <= S_FIN;
            S_FIN: begin
               if (fin_go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               i_ff        <= '0;
               pos_ff      <= '0;
               hops_ff     <= '0;
               sum_ff      <= '0;
               res_link_ff <= '0;
               idx_ff      <= req_ch.entry_index;
               x_ff        <= seed_ff;
               n_ff        <= n_sat;
               res_stat_ff <= rpcb_pkg::ST_OK;
               if (req_ch.operation == rpcb_pkg::OP_READ) begin
                  if (!built_ff) begin
                     res_stat_ff <= rpcb_pkg::ST_NOT_BUILT;
                  end else if (32'(req_ch.entry_index) > 32'(built_len_ff)) begin
                     res_stat_ff <= rpcb_pkg::ST_RANGE;
                  end
               end else if (req_ch.operation == rpcb_pkg::OP_CHASE && !built_ff) begin
                  res_stat_ff <= rpcb_pkg::ST_NOT_BUILT;
               end
            end
         end
         S_FILL: i_ff <= (i_ff + 1'b1 == n_ff) ? '0 : i_ff + 1'b1;
         S_XS:   x_ff <= x_in;
         S_MODW: if (mod_st.done) r_ff <= mod_rem[SAW-1:0];
         S_SWB:  i_ff <= (i_ff + 1'b1 == n_ff) ? '0 : i_ff + 1'b1;
         S_LWR: begin
            pos_ff <= sa_q;
            i_ff   <= i_ff + 1'b1;
         end
         S_CCHK: begin
            if (lk_q != '0 && 32'(lk_q) <= MAX_ELEMENTS) begin
               sum_ff  <= sum_ff + rpcb_pkg::SUM_W'(lk_q);
               hops_ff <= hops_ff + 1'b1;
               pos_ff  <= lk_q;
            end
         end
         S_RWAIT: res_link_ff <= lk_q;
         default: ;
      endcase
   end

   // response beat register
   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_link_ff <= rpcb_pkg::LINK_W'(res_link_ff);
         rsp_sum_ff  <= sum_ff;
         rsp_hops_ff <= rpcb_pkg::LINK_W'(hops_ff);
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.link_value = rsp_link_ff;
   assign rsp_ch.chase_sum  = rsp_sum_ff;
   assign rsp_ch.hop_count  = rsp_hops_ff;
   assign rsp_ch.status     = rsp_stat_ff;

`ifndef SYNTH
   // the remainder only lands while the sequencer waits for it
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mod_st.done |-> state_ff == S_MODW)
      else $error("modulo result outside wait state");

   // a read only reaches the table inside the built chain
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RRD |-> built_ff && 32'(idx_ff) <= 32'(built_len_ff))
      else $error("link read beyond built chain");

   // a chase never counts past the hop limit
   a_hop_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CCHK |-> 32'(hops_ff) <= MAX_ELEMENTS)
      else $error("chase exceeded hop limit");

   // once built, the chain stays built
   a_built_sticky: assert property (@(posedge clock) disable iff (reset)
      built_ff |=> built_ff)
      else $error("built flag dropped");
`endif
endmodule
